@@ rtl/twpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpq_pkg
// Shared types, constants and helpers for the two-priority work queue.
// ----------------------------------------------------------------------------
package twpq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ENTRY_W = 2 * DATA_W;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic PRIO_LOW  = 1'b0;
  localparam logic PRIO_HIGH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } twpq_state_e;

  typedef struct packed {
    logic load;    // capture the incoming item
    logic commit;  // apply the item and load the result register
  } twpq_cmd_t;

  typedef struct packed {
    logic slot_free;  // result register is empty or being drained
  } twpq_status_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

@@ rtl/two_priority_work_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_priority_work_queue
// Strict-priority pair of ring-buffer work queues with push and pop items.
// ----------------------------------------------------------------------------
// Each item passes the accept and commit states: the accept cycle captures it
// while both ring memories read their head entries into registers, and the
// commit state then applies the push or pop and loads the result register once
// the result slot is free. A new item is accepted in the cycle after the commit,
// also while the previous result still waits on out_ready_i; a result that is
// still held when the next item reaches its commit stalls that commit. The ring
// memories need no clearing after reset: entries are used only after being pushed.
module two_priority_work_queue import twpq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic              priority_req_i,
  input  logic [DATA_W-1:0] work_code_i,
  input  logic [DATA_W-1:0] work_arg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              push_accepted_o,
  output logic              work_valid_o,
  output logic [DATA_W-1:0] out_code_o,
  output logic [DATA_W-1:0] out_arg_o,
  output logic [CNT_W-1:0]  high_count_o,
  output logic [CNT_W-1:0]  low_count_o
);

  twpq_cmd_t    cmd;
  twpq_status_t status;

  twpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  twpq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (op_i),
    .priority_req_i  (priority_req_i),
    .work_code_i     (work_code_i),
    .work_arg_i      (work_arg_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .push_accepted_o (push_accepted_o),
    .work_valid_o    (work_valid_o),
    .out_code_o      (out_code_o),
    .out_arg_o       (out_arg_o),
    .high_count_o    (high_count_o),
    .low_count_o     (low_count_o)
  );

endmodule

@@ rtl/twpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpq_ctrl
// Controller: takes one item, then commits it once the result slot is free.
// ----------------------------------------------------------------------------
module twpq_ctrl import twpq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  twpq_status_t status_i,
  output twpq_cmd_t    cmd_o
);

  twpq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_COMMIT: begin
        cmd_o.commit = status_i.slot_free;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/twpq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twpq_datapath
// Two ring memories with head, tail and fill registers, item capture and
// the result register.
// ----------------------------------------------------------------------------
module twpq_datapath import twpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  twpq_cmd_t          cmd_i,
  output twpq_status_t       status_o,
  input  logic               op_i,
  input  logic               priority_req_i,
  input  logic [DATA_W-1:0]  work_code_i,
  input  logic [DATA_W-1:0]  work_arg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               push_accepted_o,
  output logic               work_valid_o,
  output logic [DATA_W-1:0]  out_code_o,
  output logic [DATA_W-1:0]  out_arg_o,
  output logic [CNT_W-1:0]   high_count_o,
  output logic [CNT_W-1:0]   low_count_o
);

  // captured item
  logic              op_q;
  logic              prio_q;
  logic [DATA_W-1:0] code_q;
  logic [DATA_W-1:0] arg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      prio_q <= priority_req_i;
      code_q <= work_code_i;
      arg_q  <= work_arg_i;
    end
  end

  // queue state
  logic [PTR_W-1:0] hi_head_q, hi_tail_q, lo_head_q, lo_tail_q;
  logic [CNT_W-1:0] hi_fill_q, hi_fill_d, lo_fill_q, lo_fill_d;

  logic hi_full, lo_full, hi_empty, lo_empty;
  logic hi_we, lo_we, hi_pop, lo_pop;

  always_comb begin
    hi_full  = (hi_fill_q == CNT_W'(DEPTH));
    lo_full  = (lo_fill_q == CNT_W'(DEPTH));
    hi_empty = (hi_fill_q == '0);
    lo_empty = (lo_fill_q == '0);
    hi_we  = cmd_i.commit && (op_q == OP_PUSH) && (prio_q == PRIO_HIGH) && !hi_full;
    lo_we  = cmd_i.commit && (op_q == OP_PUSH) && (prio_q == PRIO_LOW) && !lo_full;
    // high queue always wins a pop
    hi_pop = cmd_i.commit && (op_q == OP_POP) && !hi_empty;
    lo_pop = cmd_i.commit && (op_q == OP_POP) && hi_empty && !lo_empty;
  end

  always_comb begin
    hi_fill_d = hi_fill_q;
    lo_fill_d = lo_fill_q;
    if (hi_we)       hi_fill_d = hi_fill_q + 1'b1;
    else if (hi_pop) hi_fill_d = hi_fill_q - 1'b1;
    if (lo_we)       lo_fill_d = lo_fill_q + 1'b1;
    else if (lo_pop) lo_fill_d = lo_fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_head_q <= '0;
      hi_tail_q <= '0;
      hi_fill_q <= '0;
      lo_head_q <= '0;
      lo_tail_q <= '0;
      lo_fill_q <= '0;
    end else begin
      hi_fill_q <= hi_fill_d;
      lo_fill_q <= lo_fill_d;
      if (hi_we)  hi_tail_q <= next_ptr(hi_tail_q);
      if (lo_we)  lo_tail_q <= next_ptr(lo_tail_q);
      if (hi_pop) hi_head_q <= next_ptr(hi_head_q);
      if (lo_pop) lo_head_q <= next_ptr(lo_head_q);
    end
  end

  // ring memories, head entry read every cycle
  logic [ENTRY_W-1:0] hi_mem [DEPTH];
  logic [ENTRY_W-1:0] lo_mem [DEPTH];
  logic [ENTRY_W-1:0] hi_rd_q, lo_rd_q;

  always_ff @(posedge clk_i) begin
    if (hi_we) hi_mem[hi_tail_q] <= {code_q, arg_q};
    hi_rd_q <= hi_mem[hi_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (lo_we) lo_mem[lo_tail_q] <= {code_q, arg_q};
    lo_rd_q <= lo_mem[lo_head_q];
  end

  // result register
  logic               out_valid_q;
  logic               push_acc_q;
  logic               work_valid_q;
  logic [DATA_W-1:0]  out_code_q;
  logic [DATA_W-1:0]  out_arg_q;
  logic [CNT_W-1:0]   hi_cnt_q;
  logic [CNT_W-1:0]   lo_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      push_acc_q   <= hi_we | lo_we;
      work_valid_q <= hi_pop | lo_pop;
      hi_cnt_q     <= hi_fill_d;
      lo_cnt_q     <= lo_fill_d;
      if (hi_pop) begin
        out_code_q <= hi_rd_q[ENTRY_W-1:DATA_W];
        out_arg_q  <= hi_rd_q[DATA_W-1:0];
      end else if (lo_pop) begin
        out_code_q <= lo_rd_q[ENTRY_W-1:DATA_W];
        out_arg_q  <= lo_rd_q[DATA_W-1:0];
      end else begin
        out_code_q <= '0;
        out_arg_q  <= '0;
      end
    end
  end

  assign status_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign push_accepted_o = push_acc_q;
  assign work_valid_o    = work_valid_q;
  assign out_code_o      = out_code_q;
  assign out_arg_o       = out_arg_q;
  assign high_count_o    = hi_cnt_q;
  assign low_count_o     = lo_cnt_q;

`ifndef SYNTHESIS
  a_hi_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_fill_q <= CNT_W'(DEPTH))
    else $error("high queue fill above depth");

  a_lo_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_fill_q <= CNT_W'(DEPTH))
    else $error("low queue fill above depth");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not load the result register");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(hi_fill_q) && $stable(lo_fill_q))
    else $error("fill changed without a commit");

  a_pop_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (op_q == OP_POP) && !hi_empty |=> $stable(lo_fill_q))
    else $error("low queue popped while high queue held entries");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-priority work queue: a queue-fed driver
// offers push and pop items with random gaps, a scoreboard predicts every
// result from its own copy of both rings, and a receiver with random and
// long stalls drains the results, which are compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import twpq_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned CALM_TAIL   = 100;     // last items run with no idling
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic              op;
    logic              prio;
    logic [DATA_W-1:0] code;
    logic [DATA_W-1:0] arg;
    logic              sync;  // wait until every result is back before offering
    logic              hold;  // receiver holds off for a long stretch
  } work_item_t;

  typedef struct packed {
    logic              accepted;
    logic              valid;
    logic [DATA_W-1:0] code;
    logic [DATA_W-1:0] arg;
    logic [CNT_W-1:0]  high_cnt;
    logic [CNT_W-1:0]  low_cnt;
  } outcome_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              op_i           = OP_PUSH;
  logic              priority_req_i = PRIO_LOW;
  logic [DATA_W-1:0] work_code_i    = '0;
  logic [DATA_W-1:0] work_arg_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              push_accepted_o;
  logic              work_valid_o;
  logic [DATA_W-1:0] out_code_o;
  logic [DATA_W-1:0] out_arg_o;
  logic [CNT_W-1:0]  high_count_o;
  logic [CNT_W-1:0]  low_count_o;

  work_item_t  item_q[$];
  outcome_t    outcome_q[$];

  // ring copies, indexed by priority
  logic [2*DATA_W-1:0] ring_mem [2][DEPTH];
  int unsigned         ring_head [2] = '{0, 0};
  int unsigned         ring_tail [2] = '{0, 0};
  int unsigned         ring_fill [2] = '{0, 0};

  logic        in_taken     = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned rx_gap       = 0;
  int unsigned rx_hold_left = 0;
  int unsigned cycle_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned n_stored     = 0;
  int unsigned n_refused    = 0;
  int unsigned n_popped     = 0;
  int unsigned n_empty_pops = 0;

  two_priority_work_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .work_code_i    (work_code_i),
    .work_arg_i     (work_arg_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .push_accepted_o(push_accepted_o),
    .work_valid_o   (work_valid_o),
    .out_code_o     (out_code_o),
    .out_arg_o      (out_arg_o),
    .high_count_o   (high_count_o),
    .low_count_o    (low_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned ring_step(int unsigned ptr);
    return (ptr == DEPTH - 1) ? 0 : ptr + 1;
  endfunction

  // applies one item to the ring copies and returns the result it must produce
  function automatic outcome_t predict_outcome(work_item_t it);
    outcome_t    res;
    int unsigned q;
    logic        found;
    res   = '0;
    found = 1'b0;
    if (it.op == OP_PUSH) begin
      q = int'(it.prio);
      if (ring_fill[q] < DEPTH) begin
        ring_mem[q][ring_tail[q]] = {it.code, it.arg};
        ring_tail[q] = ring_step(ring_tail[q]);
        ring_fill[q]++;
        res.accepted = 1'b1;
        n_stored++;
      end else begin
        n_refused++;
      end
    end else begin
      if (ring_fill[PRIO_HIGH] != 0) begin
        q     = int'(PRIO_HIGH);
        found = 1'b1;
      end else if (ring_fill[PRIO_LOW] != 0) begin
        q     = int'(PRIO_LOW);
        found = 1'b1;
      end
      if (found) begin
        {res.code, res.arg} = ring_mem[q][ring_head[q]];
        ring_head[q] = ring_step(ring_head[q]);
        ring_fill[q]--;
        res.valid = 1'b1;
        n_popped++;
      end else begin
        n_empty_pops++;
      end
    end
    res.high_cnt = CNT_W'(ring_fill[PRIO_HIGH]);
    res.low_cnt  = CNT_W'(ring_fill[PRIO_LOW]);
    return res;
  endfunction

  // sender: holds the payload until taken, then idles or offers the next item
  always @(negedge clk_i) begin : feed
    work_item_t nxt;
    logic       offer;
    nxt   = '0;
    offer = 1'b0;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (src_gap != 0) begin
        src_gap--;
      end else if (item_q.size() != 0 && !(item_q[0].sync && outcome_q.size() != 0)) begin
        if (item_q.size() >= CALM_TAIL && rx_hold_left == 0 && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 11) - 1;
        end else begin
          nxt   = item_q.pop_front();
          offer = 1'b1;
          if (nxt.hold) begin
            hold_request = 1'b1;
          end
        end
      end
      in_valid_i <= offer;
      if (offer) begin
        op_i           <= nxt.op;
        priority_req_i <= nxt.prio;
        work_code_i    <= nxt.code;
        work_arg_i     <= nxt.arg;
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  always @(negedge clk_i) begin : drain
    logic rdy;
    rdy = 1'b1;
    if (rst_ni) begin
      if (hold_request) begin
        hold_request = 1'b0;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        rdy = 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else if (item_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 11) - 1;
        rdy    = 1'b0;
      end
      out_ready_i <= rdy;
    end
  end

  // scoreboard: results are checked before the item taken at the same edge is predicted
  always @(posedge clk_i) begin : observe
    outcome_t   want;
    work_item_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result %0d: code %h arg %h", results_seen, out_code_o,
                     out_arg_o);
          end
        end else begin
          want = outcome_q.pop_front();
          if (push_accepted_o !== want.accepted || work_valid_o !== want.valid ||
              out_code_o !== want.code || out_arg_o !== want.arg ||
              high_count_o !== want.high_cnt || low_count_o !== want.low_cnt) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display(
                "mismatch on result %0d: expected acc %0b vld %0b code %h arg %h hi %0d lo %0d",
                results_seen, want.accepted, want.valid, want.code, want.arg,
                want.high_cnt, want.low_cnt);
              $display(
                "                        actual   acc %0b vld %0b code %h arg %h hi %0d lo %0d",
                push_accepted_o, work_valid_o, out_code_o, out_arg_o,
                high_count_o, low_count_o);
            end
          end
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        seen      = '0;
        seen.op   = op_i;
        seen.prio = priority_req_i;
        seen.code = work_code_i;
        seen.arg  = work_arg_i;
        outcome_q.push_back(predict_outcome(seen));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding", outcome_q.size());
      $display("[two_priority_work_queue] ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic op, input logic prio, input logic [DATA_W-1:0] code,
                          input logic [DATA_W-1:0] arg, input logic sync = 1'b0,
                          input logic hold = 1'b0);
    work_item_t it;
    it      = '0;
    it.op   = op;
    it.prio = prio;
    it.code = code;
    it.arg  = arg;
    it.sync = sync;
    it.hold = hold;
    item_q.push_back(it);
  endtask

  // mostly random, with zero and all-ones mixed in
  function automatic logic [DATA_W-1:0] field_value();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned kind;
    int unsigned run_len;
    int unsigned next_hold_at;
    logic        run_prio;
    logic        op;
    logic        pause;
    logic        stall;

    // directed: empty pop, field extremes, zero code, priority order
    add_item(OP_POP,  PRIO_HIGH, '1, '1);
    add_item(OP_PUSH, PRIO_LOW,  '1, '0);
    add_item(OP_PUSH, PRIO_HIGH, '0, '1);
    add_item(OP_PUSH, PRIO_LOW,  '0, '0);
    add_item(OP_PUSH, PRIO_HIGH, '1, '1);
    add_item(OP_POP,  PRIO_LOW,  '0, '0);
    add_item(OP_POP,  PRIO_LOW,  '1, '0);
    add_item(OP_POP,  PRIO_HIGH, '0, '0);
    add_item(OP_POP,  PRIO_HIGH, '0, '1);
    add_item(OP_POP,  PRIO_LOW,  '0, '0);
    add_item(OP_PUSH, PRIO_LOW,  64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 1'b1);
    add_item(OP_PUSH, PRIO_HIGH, 64'h7fff_ffff_ffff_fffe, 64'hfedc_ba98_7654_3210);
    add_item(OP_POP,  PRIO_LOW,  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    add_item(OP_POP,  PRIO_HIGH, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    add_item(OP_POP,  PRIO_HIGH, '0, '0);

    // random runs of fills, drains, mixed traffic and noise
    next_hold_at = 250;
    pause        = 1'b1;
    while (item_q.size() < ITEM_TARGET) begin
      kind  = $urandom_range(0, 9);
      stall = (item_q.size() >= next_hold_at);
      if (stall) begin
        next_hold_at += 400;
      end
      run_prio = 1'($urandom_range(0, 1));
      case (kind)
        0, 1, 2: run_len = $urandom_range(6, 22);
        3, 4:    run_len = $urandom_range(6, 24);
        9:       run_len = $urandom_range(1, 4);
        default: run_len = $urandom_range(8, 30);
      endcase
      for (int k = 0; k < run_len; k++) begin
        case (kind)
          0, 1, 2: op = OP_PUSH;
          3, 4:    op = OP_POP;
          9:       op = 1'($urandom_range(0, 1));
          default: op = ($urandom_range(0, 99) < 55) ? OP_PUSH : OP_POP;
        endcase
        if (kind >= 5) begin
          run_prio = 1'($urandom_range(0, 1));
        end
        add_item(op, run_prio, field_value(), field_value(), pause && k == 0, stall && k == 0);
      end
      pause = ($urandom_range(0, 11) == 0);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (item_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d results: %0d pushes stored, %0d refused on a full queue",
             results_seen, n_stored, n_refused);
    $display("%0d pops returned work, %0d found both queues empty, %0d failures",
             n_popped, n_empty_pops, fail_count);
    if (fail_count == 0) begin
      $display("[two_priority_work_queue] OK");
    end else begin
      $display("[two_priority_work_queue] ERROR");
    end
    $finish;
  end

endmodule

@@ two_priority_work_queue.f @@
rtl/twpq_pkg.sv
rtl/twpq_ctrl.sv
rtl/twpq_datapath.sv
rtl/two_priority_work_queue.sv
tb/sv/testbench.sv
